// File: rtl/assert_macros.svh
// Assertion helpers; clk and rst_n come from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: rtl/tllo_pkg.sv
package tllo_pkg;

    localparam int DEF_MAX_NODES = 16;
    localparam int IDX_W         = 4;
    localparam int RES_LIMIT     = 8;
    localparam int CNT_W         = $clog2(RES_LIMIT + 1);

    typedef struct packed {
        logic             present;
        logic [IDX_W-1:0] idx;
    } link_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_START,
        ST_POP,
        ST_NODE,
        ST_KIDS,
        ST_RIGHT,
        ST_FIN
    } state_t;

endpackage

// File: rtl/tllo_store.sv
module tllo_store #(
    parameter int MAX_NODES = tllo_pkg::DEF_MAX_NODES
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  tllo_pkg::link_t              wr_left,
    input  tllo_pkg::link_t              wr_right,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    output tllo_pkg::link_t              rd_left,
    output tllo_pkg::link_t              rd_right
);

    tllo_pkg::link_t left_mem [MAX_NODES];
    tllo_pkg::link_t right_mem [MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= wr_left;
            right_mem[wr_addr] <= wr_right;
        end
        if (rd_en)
        begin
            rd_left  <= left_mem[rd_addr];
            rd_right <= right_mem[rd_addr];
        end
    end

endmodule

// File: rtl/tllo_queue.sv
module tllo_queue #(
    parameter int MAX_NODES = tllo_pkg::DEF_MAX_NODES
) (
    input  logic                         clk,
    input  logic                         wr_en,
    input  logic [$clog2(MAX_NODES)-1:0] wr_addr,
    input  logic [tllo_pkg::IDX_W-1:0]   wr_data,
    input  logic                         rd_en,
    input  logic [$clog2(MAX_NODES)-1:0] rd_addr,
    output logic [tllo_pkg::IDX_W-1:0]   rd_data
);

    logic [tllo_pkg::IDX_W-1:0] queue_mem [MAX_NODES];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            queue_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= queue_mem[rd_addr];
        end
    end

endmodule

// File: rtl/tllo_ctrl.sv
module tllo_ctrl #(
    parameter int MAX_NODES = tllo_pkg::DEF_MAX_NODES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [tllo_pkg::IDX_W-1:0]   left_child,
    input  logic                         left_present,
    input  logic [tllo_pkg::IDX_W-1:0]   right_child,
    input  logic                         right_present,
    input  logic                         last_node,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [tllo_pkg::IDX_W-1:0]   leaf_index,
    output logic                         last_leaf,
    output logic                         tree_error,
    output logic                         st_wr_en,
    output logic [$clog2(MAX_NODES)-1:0] st_wr_addr,
    output tllo_pkg::link_t              st_wr_left,
    output tllo_pkg::link_t              st_wr_right,
    output logic                         st_rd_en,
    output logic [$clog2(MAX_NODES)-1:0] st_rd_addr,
    input  tllo_pkg::link_t              st_rd_left,
    input  tllo_pkg::link_t              st_rd_right,
    output logic                         q_wr_en,
    output logic [$clog2(MAX_NODES)-1:0] q_wr_addr,
    output logic [tllo_pkg::IDX_W-1:0]   q_wr_data,
    output logic                         q_rd_en,
    output logic [$clog2(MAX_NODES)-1:0] q_rd_addr,
    input  logic [tllo_pkg::IDX_W-1:0]   q_rd_data
);

    localparam int IW   = tllo_pkg::IDX_W;
    localparam int NW   = $clog2(MAX_NODES);
    localparam int CW   = $clog2(MAX_NODES + 1);
    localparam int CMPW = (CW > IW) ? CW : IW;
    localparam int MK   = (MAX_NODES < 16) ? MAX_NODES : 16;
    localparam int KW   = tllo_pkg::CNT_W;

    tllo_pkg::state_t state_reg, state_next;

    logic [CW-1:0] node_count_reg, node_count_next;
    logic          too_many_reg, too_many_next;
    logic          any_child_reg, any_child_next;
    logic [IW-1:0] max_child_reg, max_child_next;
    logic [MK-1:0] marks_reg, marks_next;
    logic [NW-1:0] head_reg, head_next;
    logic [NW-1:0] tail_reg, tail_next;
    logic [CW-1:0] visits_reg, visits_next;
    logic [KW-1:0] count_reg, count_next;
    logic          pend_valid_reg, pend_valid_next;
    logic [IW-1:0] pend_idx_reg, pend_idx_next;
    logic          out_valid_reg, out_valid_next;
    logic [IW-1:0] leaf_index_reg, leaf_index_next;
    logic          last_leaf_reg, last_leaf_next;
    logic          tree_error_reg, tree_error_next;

    logic          in_fire;
    logic          out_free;
    logic          root_found;
    logic [IW-1:0] root_idx;
    logic          check_err;
    logic          walk_go;
    logic          x_ok;
    logic          is_leaf;
    logic          kids_stall;
    logic [NW-1:0] head_inc;
    logic [NW-1:0] tail_inc;
    logic          enq_ok;

    function automatic logic [NW-1:0] ptr_inc(input logic [NW-1:0] p);
        return (p == NW'(MAX_NODES - 1)) ? '0 : p + NW'(1);
    endfunction

    assign in_ready   = (state_reg == tllo_pkg::ST_LOAD);
    assign in_fire    = in_valid && in_ready;
    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign leaf_index = leaf_index_reg;
    assign last_leaf  = last_leaf_reg;
    assign tree_error = tree_error_reg;

    assign head_inc   = ptr_inc(head_reg);
    assign tail_inc   = ptr_inc(tail_reg);
    assign enq_ok     = (tail_inc != head_reg);
    assign walk_go    = (head_reg != tail_reg) && (visits_reg < node_count_reg)
                        && (count_reg < KW'(tllo_pkg::RES_LIMIT));
    assign x_ok       = (CMPW'(q_rd_data) < CMPW'(node_count_reg));
    assign is_leaf    = !st_rd_left.present && !st_rd_right.present;
    assign kids_stall = is_leaf && pend_valid_reg && !out_free;

    // lowest unmarked node; nodes past the mark range can never be children
    always_comb
    begin
        root_found = 1'b0;
        root_idx   = '0;
        for (int i = MK - 1; i >= 0; i--)
        begin
            if (!marks_reg[i] && (CMPW'(i) < CMPW'(node_count_reg)))
            begin
                root_found = 1'b1;
                root_idx   = IW'(i);
            end
        end
        if (!root_found && (CMPW'(MK) < CMPW'(node_count_reg)))
        begin
            root_found = 1'b1;
            root_idx   = IW'(MK);
        end
    end

    assign check_err = too_many_reg || !root_found
                       || (any_child_reg && (CMPW'(max_child_reg) >= CMPW'(node_count_reg)));

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            tllo_pkg::ST_LOAD:
            begin
                if (in_fire && last_node)
                begin
                    state_next = tllo_pkg::ST_START;
                end
            end
            tllo_pkg::ST_START:
            begin
                state_next = check_err ? tllo_pkg::ST_FIN : tllo_pkg::ST_POP;
            end
            tllo_pkg::ST_POP:
            begin
                state_next = walk_go ? tllo_pkg::ST_NODE : tllo_pkg::ST_FIN;
            end
            tllo_pkg::ST_NODE:
            begin
                state_next = x_ok ? tllo_pkg::ST_KIDS : tllo_pkg::ST_POP;
            end
            tllo_pkg::ST_KIDS:
            begin
                if (!kids_stall)
                begin
                    state_next = st_rd_right.present ? tllo_pkg::ST_RIGHT : tllo_pkg::ST_POP;
                end
            end
            tllo_pkg::ST_RIGHT:
            begin
                state_next = tllo_pkg::ST_POP;
            end
            tllo_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = tllo_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = tllo_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        node_count_next = node_count_reg;
        too_many_next   = too_many_reg;
        any_child_next  = any_child_reg;
        max_child_next  = max_child_reg;
        marks_next      = marks_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        visits_next     = visits_reg;
        count_next      = count_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        leaf_index_next = leaf_index_reg;
        last_leaf_next  = last_leaf_reg;
        tree_error_next = tree_error_reg;

        st_wr_en    = 1'b0;
        st_wr_addr  = NW'(node_count_reg);
        st_wr_left  = '{present: left_present, idx: left_child};
        st_wr_right = '{present: right_present, idx: right_child};
        st_rd_en    = 1'b0;
        st_rd_addr  = NW'(q_rd_data);
        q_wr_en     = 1'b0;
        q_wr_addr   = tail_inc;
        q_wr_data   = st_rd_left.idx;
        q_rd_en     = 1'b0;
        q_rd_addr   = head_inc;

        case (state_reg)
            tllo_pkg::ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (node_count_reg < CW'(MAX_NODES))
                    begin
                        st_wr_en        = 1'b1;
                        node_count_next = node_count_reg + CW'(1);
                        for (int i = 0; i < MK; i++)
                        begin
                            if ((left_present && (left_child == IW'(i)))
                                || (right_present && (right_child == IW'(i))))
                            begin
                                marks_next[i] = 1'b1;
                            end
                        end
                        if (left_present && (!any_child_next || left_child > max_child_next))
                        begin
                            max_child_next = left_child;
                            any_child_next = 1'b1;
                        end
                        if (right_present
                            && (!any_child_next || right_child > max_child_next))
                        begin
                            max_child_next = right_child;
                            any_child_next = 1'b1;
                        end
                    end
                    else
                    begin
                        too_many_next = 1'b1;
                    end
                end
            end
            tllo_pkg::ST_START:
            begin
                head_next       = '0;
                tail_next       = '0;
                visits_next     = '0;
                count_next      = '0;
                pend_valid_next = 1'b0;
                if (!check_err)
                begin
                    q_wr_en   = 1'b1;
                    q_wr_addr = NW'(1);
                    q_wr_data = root_idx;
                    tail_next = NW'(1);
                end
            end
            tllo_pkg::ST_POP:
            begin
                if (walk_go)
                begin
                    q_rd_en     = 1'b1;
                    head_next   = head_inc;
                    visits_next = visits_reg + CW'(1);
                end
            end
            tllo_pkg::ST_NODE:
            begin
                st_rd_en = x_ok;
            end
            tllo_pkg::ST_KIDS:
            begin
                if (!kids_stall)
                begin
                    if (st_rd_left.present && enq_ok)
                    begin
                        q_wr_en   = 1'b1;
                        tail_next = tail_inc;
                    end
                    if (is_leaf)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            leaf_index_next = pend_idx_reg;
                            last_leaf_next  = 1'b0;
                            tree_error_next = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = q_rd_data;
                        count_next      = count_reg + KW'(1);
                    end
                end
            end
            tllo_pkg::ST_RIGHT:
            begin
                q_wr_data = st_rd_right.idx;
                if (enq_ok)
                begin
                    q_wr_en   = 1'b1;
                    tail_next = tail_inc;
                end
            end
            tllo_pkg::ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    last_leaf_next  = 1'b1;
                    leaf_index_next = pend_valid_reg ? pend_idx_reg : '0;
                    tree_error_next = !pend_valid_reg;
                    pend_valid_next = 1'b0;
                    node_count_next = '0;
                    too_many_next   = 1'b0;
                    any_child_next  = 1'b0;
                    max_child_next  = '0;
                    marks_next      = '0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tllo_pkg::ST_LOAD;
            node_count_reg <= '0;
            too_many_reg   <= 1'b0;
            any_child_reg  <= 1'b0;
            marks_reg      <= '0;
            head_reg       <= '0;
            tail_reg       <= '0;
            visits_reg     <= '0;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            too_many_reg   <= too_many_next;
            any_child_reg  <= any_child_next;
            marks_reg      <= marks_next;
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            visits_reg     <= visits_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        max_child_reg  <= max_child_next;
        pend_idx_reg   <= pend_idx_next;
        leaf_index_reg <= leaf_index_next;
        last_leaf_reg  <= last_leaf_next;
        tree_error_reg <= tree_error_next;
    end

endmodule

// File: rtl/tree_leaves_level_order_top.sv
// Level-order leaf lister. Nodes of a binary tree arrive one per beat, numbered in arrival
// order, and are taken at one per cycle into a node store. The beat flagged last_node ends
// loading; the block then drops in_ready, checks the tree (root, child range, node overflow)
// and walks it breadth-first through a queue memory. Each dequeue steps through a queue read,
// a node store read and the enqueue of the left child, plus an enqueue of the right child
// when the node also has one; both memories have registered reads. A dequeued index at or
// above the node count skips the node store read. The walk ends after at most MAX_NODES
// dequeues or eight leaves; the pop state finds it done and the final state delivers the last
// result. Leaves are delivered one beat each with last_leaf on the final one; a rejected tree
// or a walk with no leaf gives one beat with tree_error set. A slow consumer stalls the walk
// when the output register and the one-deep pending leaf are both full.
module tree_leaves_level_order_top #(
    parameter int MAX_NODES = tllo_pkg::DEF_MAX_NODES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [tllo_pkg::IDX_W-1:0] left_child,
    input  logic                       left_present,
    input  logic [tllo_pkg::IDX_W-1:0] right_child,
    input  logic                       right_present,
    input  logic                       last_node,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [tllo_pkg::IDX_W-1:0] leaf_index,
    output logic                       last_leaf,
    output logic                       tree_error
);

    localparam int NW = $clog2(MAX_NODES);

    logic                       st_wr_en;
    logic [NW-1:0]              st_wr_addr;
    tllo_pkg::link_t            st_wr_left;
    tllo_pkg::link_t            st_wr_right;
    logic                       st_rd_en;
    logic [NW-1:0]              st_rd_addr;
    tllo_pkg::link_t            st_rd_left;
    tllo_pkg::link_t            st_rd_right;
    logic                       q_wr_en;
    logic [NW-1:0]              q_wr_addr;
    logic [tllo_pkg::IDX_W-1:0] q_wr_data;
    logic                       q_rd_en;
    logic [NW-1:0]              q_rd_addr;
    logic [tllo_pkg::IDX_W-1:0] q_rd_data;

    tllo_store #(
        .MAX_NODES (MAX_NODES)
    ) u_store (
        .clk      (clk),
        .wr_en    (st_wr_en),
        .wr_addr  (st_wr_addr),
        .wr_left  (st_wr_left),
        .wr_right (st_wr_right),
        .rd_en    (st_rd_en),
        .rd_addr  (st_rd_addr),
        .rd_left  (st_rd_left),
        .rd_right (st_rd_right)
    );

    tllo_queue #(
        .MAX_NODES (MAX_NODES)
    ) u_queue (
        .clk     (clk),
        .wr_en   (q_wr_en),
        .wr_addr (q_wr_addr),
        .wr_data (q_wr_data),
        .rd_en   (q_rd_en),
        .rd_addr (q_rd_addr),
        .rd_data (q_rd_data)
    );

    tllo_ctrl #(
        .MAX_NODES (MAX_NODES)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .left_child    (left_child),
        .left_present  (left_present),
        .right_child   (right_child),
        .right_present (right_present),
        .last_node     (last_node),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .leaf_index    (leaf_index),
        .last_leaf     (last_leaf),
        .tree_error    (tree_error),
        .st_wr_en      (st_wr_en),
        .st_wr_addr    (st_wr_addr),
        .st_wr_left    (st_wr_left),
        .st_wr_right   (st_wr_right),
        .st_rd_en      (st_rd_en),
        .st_rd_addr    (st_rd_addr),
        .st_rd_left    (st_rd_left),
        .st_rd_right   (st_rd_right),
        .q_wr_en       (q_wr_en),
        .q_wr_addr     (q_wr_addr),
        .q_wr_data     (q_wr_data),
        .q_rd_en       (q_rd_en),
        .q_rd_addr     (q_rd_addr),
        .q_rd_data     (q_rd_data)
    );

endmodule

// File: rtl/tllo_checker.sv
`include "assert_macros.svh"

module tllo_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_valid,
    input logic                       in_ready,
    input logic                       last_node,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [tllo_pkg::IDX_W-1:0] leaf_index,
    input logic                       last_leaf,
    input logic                       tree_error
);

    // an error beat is always the lone, final beat of its tree
    `ASSERT_IMPLIES(a_err_beat, out_valid && tree_error, last_leaf && (leaf_index == '0))

    // input is blocked right after the final node beat
    `ASSERT_NEXT(a_walk_blocks_input, in_valid && in_ready && last_node, !in_ready)

    // a stalled beat holds its payload
    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(leaf_index) && $stable(last_leaf) && $stable(tree_error))

    // non-final leaves only show up while a walk is running
    `ASSERT_IMPLIES(a_mid_beat_in_walk, out_valid && !last_leaf, !in_ready)

endmodule

bind tree_leaves_level_order_top tllo_checker u_tllo_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .last_node  (last_node),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .leaf_index (leaf_index),
    .last_leaf  (last_leaf),
    .tree_error (tree_error)
);

// File: bench/tree_leaves_level_order_checker.sv
`timescale 1ns / 1ps

module tree_leaves_level_order_checker #(
    parameter int MAX_NODES = tllo_pkg::DEF_MAX_NODES
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic [tllo_pkg::IDX_W-1:0] left_child,
    input  logic                       left_present,
    input  logic [tllo_pkg::IDX_W-1:0] right_child,
    input  logic                       right_present,
    input  logic                       last_node,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic [tllo_pkg::IDX_W-1:0] leaf_index,
    input  logic                       last_leaf,
    input  logic                       tree_error,
    output int                         fail_count,
    output int                         pending_leaves
);

    localparam int IDX_W = tllo_pkg::IDX_W;
    localparam int PRINT_CAP = 20;

    typedef struct packed {
        logic [IDX_W-1:0] leaf;
        logic             last;
        logic             err;
    } leaf_beat_t;

    tllo_pkg::link_t      left_links  [MAX_NODES];
    tllo_pkg::link_t      right_links [MAX_NODES];
    logic [MAX_NODES-1:0] child_marks;
    int                   nodes_loaded;
    bit                   node_overflow;
    logic [IDX_W-1:0]     walk_ring [MAX_NODES];
    int                   ring_head;
    int                   ring_tail;
    leaf_beat_t           leaf_expect_q [$];

    initial
    begin
        fail_count     = 0;
        pending_leaves = 0;
        child_marks    = '0;
        nodes_loaded   = 0;
        node_overflow  = 1'b0;
        ring_head      = 0;
        ring_tail      = 0;
    end

    task automatic report_mismatch(string what, int got, int want);
        if (fail_count < PRINT_CAP)
            $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
        fail_count++;
    endtask

    // full ring drops the child
    function automatic void ring_push(logic [IDX_W-1:0] v);
        int nxt;
        nxt = (ring_tail + 1) % MAX_NODES;
        if (nxt != ring_head)
        begin
            ring_tail            = nxt;
            walk_ring[ring_tail] = v;
        end
    endfunction

    task automatic predict_leaves(tllo_pkg::link_t lk, tllo_pkg::link_t rk, logic last);
        int         n;
        int         root;
        int         visits;
        int         found;
        int         x;
        bit         bad;
        leaf_beat_t batch [tllo_pkg::RES_LIMIT];

        if (nodes_loaded < MAX_NODES)
        begin
            left_links[nodes_loaded]  = lk;
            right_links[nodes_loaded] = rk;
            if (lk.present && int'(lk.idx) < MAX_NODES)
                child_marks[lk.idx] = 1'b1;
            if (rk.present && int'(rk.idx) < MAX_NODES)
                child_marks[rk.idx] = 1'b1;
            nodes_loaded++;
        end
        else
            node_overflow = 1'b1;

        if (!last)
            return;

        n   = nodes_loaded;
        bad = node_overflow;
        for (int i = 0; i < n; i++)
        begin
            if (left_links[i].present && int'(left_links[i].idx) >= n)
                bad = 1'b1;
            if (right_links[i].present && int'(right_links[i].idx) >= n)
                bad = 1'b1;
        end
        root = n;
        for (int i = n - 1; i >= 0; i--)
            if (!child_marks[i])
                root = i;
        if (root >= n)
            bad = 1'b1;

        found = 0;
        if (!bad)
        begin
            ring_head = 0;
            ring_tail = 0;
            ring_push(IDX_W'(root));
            visits = 0;
            while (ring_head != ring_tail && visits < n && found < tllo_pkg::RES_LIMIT)
            begin
                ring_head = (ring_head + 1) % MAX_NODES;
                x         = int'(walk_ring[ring_head]);
                visits++;
                if (x < n)
                begin
                    if (left_links[x].present)
                        ring_push(left_links[x].idx);
                    if (right_links[x].present)
                        ring_push(right_links[x].idx);
                    if (!left_links[x].present && !right_links[x].present)
                    begin
                        batch[found] = leaf_beat_t'{leaf: IDX_W'(x), last: 1'b0, err: 1'b0};
                        found++;
                    end
                end
            end
        end

        // rejected tree or a walk with no leaf: one error beat
        if (bad || found == 0)
            leaf_expect_q.push_back(leaf_beat_t'{leaf: '0, last: 1'b1, err: 1'b1});
        else
        begin
            batch[found-1].last = 1'b1;
            for (int i = 0; i < found; i++)
                leaf_expect_q.push_back(batch[i]);
        end

        child_marks   = '0;
        nodes_loaded  = 0;
        node_overflow = 1'b0;
    endtask

    always @(posedge clk)
    begin : watch
        leaf_beat_t want;
        if (rst_n === 1'b1)
        begin
            if (in_valid === 1'b1 && in_ready === 1'b1)
                predict_leaves(tllo_pkg::link_t'{present: left_present, idx: left_child},
                               tllo_pkg::link_t'{present: right_present, idx: right_child},
                               last_node);
            if (out_valid === 1'b1 && out_ready === 1'b1)
            begin
                if (leaf_expect_q.size() == 0)
                    report_mismatch("leaf beat with none pending", int'(leaf_index), 0);
                else
                begin
                    want = leaf_expect_q.pop_front();
                    if (leaf_index !== want.leaf)
                        report_mismatch("leaf_index", int'(leaf_index), int'(want.leaf));
                    if (last_leaf !== want.last)
                        report_mismatch("last_leaf", int'(last_leaf), int'(want.last));
                    if (tree_error !== want.err)
                        report_mismatch("tree_error", int'(tree_error), int'(want.err));
                end
            end
            pending_leaves = leaf_expect_q.size();
        end
    end

endmodule

// File: bench/tb_tree_leaves_level_order_top.sv
`timescale 1ns / 1ps

module tb_tree_leaves_level_order_top;

    localparam int IDX_W        = tllo_pkg::IDX_W;
    localparam int NODE_ITEMS   = 460;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_AT_BEAT = 30;
    localparam int PLAN_DEPTH   = 24;

    logic             clk;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [IDX_W-1:0] left_child;
    logic             left_present;
    logic [IDX_W-1:0] right_child;
    logic             right_present;
    logic             last_node;
    logic             out_valid;
    logic             out_ready;
    logic [IDX_W-1:0] leaf_index;
    logic             last_leaf;
    logic             tree_error;

    int fail_count;
    int pending_leaves;
    int nodes_sent;
    int leaf_beats;
    bit tx_eager;
    bit rx_eager;

    logic [IDX_W-1:0] plan_l  [PLAN_DEPTH];
    logic             plan_lp [PLAN_DEPTH];
    logic [IDX_W-1:0] plan_r  [PLAN_DEPTH];
    logic             plan_rp [PLAN_DEPTH];
    int               plan_n;

    tree_leaves_level_order_top uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .left_child    (left_child),
        .left_present  (left_present),
        .right_child   (right_child),
        .right_present (right_present),
        .last_node     (last_node),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .leaf_index    (leaf_index),
        .last_leaf     (last_leaf),
        .tree_error    (tree_error)
    );

    tree_leaves_level_order_checker leaf_monitor (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .left_child     (left_child),
        .left_present   (left_present),
        .right_child    (right_child),
        .right_present  (right_present),
        .last_node      (last_node),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .leaf_index     (leaf_index),
        .last_leaf      (last_leaf),
        .tree_error     (tree_error),
        .fail_count     (fail_count),
        .pending_leaves (pending_leaves)
    );

    initial
        clk = 1'b0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // leaf sink: random stalls, eager stretches, one long hold-off
    initial
    begin : sink
        int stall;
        out_ready <= 1'b0;
        leaf_beats = 0;
        rx_eager   = 1'b0;
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever
        begin
            if (leaf_beats % 16 == 0)
                rx_eager = ($urandom_range(0, 3) == 0);
            stall = rx_eager ? 0 : $urandom_range(0, 12);
            if (leaf_beats == HOLD_AT_BEAT)
                stall = LONG_HOLD;
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            leaf_beats++;
        end
    end

    task automatic offer_node(logic [IDX_W-1:0] l, logic lp, logic [IDX_W-1:0] r, logic rp,
                              logic last);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 12);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid      <= 1'b1;
        left_child    <= l;
        left_present  <= lp;
        right_child   <= r;
        right_present <= rp;
        last_node     <= last;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        nodes_sent++;
    endtask

    task automatic offer_plan();
        for (int i = 0; i < plan_n; i++)
            offer_node(plan_l[i], plan_lp[i], plan_r[i], plan_rp[i], i == plan_n - 1);
    endtask

    task automatic drain_leaves();
        in_valid <= 1'b0;
        @(posedge clk);
        do
            @(negedge clk);
        while (pending_leaves != 0);
        @(posedge clk);
    endtask

    task automatic plan_noise(int n);
        for (int i = 0; i < n; i++)
        begin
            plan_l[i]  = IDX_W'($urandom_range(0, 15));
            plan_lp[i] = 1'($urandom_range(0, 1));
            plan_r[i]  = IDX_W'($urandom_range(0, 15));
            plan_rp[i] = 1'($urandom_range(0, 1));
        end
        plan_n = n;
    endtask

    // proper binary tree, root anywhere
    task automatic plan_shaped(int n);
        int order [16];
        int j;
        int tmp;
        int par;
        bit placed;
        for (int i = 0; i < n; i++)
        begin
            order[i]   = i;
            plan_l[i]  = IDX_W'($urandom_range(0, 15));
            plan_lp[i] = 1'b0;
            plan_r[i]  = IDX_W'($urandom_range(0, 15));
            plan_rp[i] = 1'b0;
        end
        for (int i = n - 1; i > 0; i--)
        begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int k = 1; k < n; k++)
        begin
            placed = 1'b0;
            while (!placed)
            begin
                par = order[$urandom_range(0, k - 1)];
                if ($urandom_range(0, 1) == 0 && !plan_lp[par])
                begin
                    plan_lp[par] = 1'b1;
                    plan_l[par]  = IDX_W'(order[k]);
                    placed       = 1'b1;
                end
                else if (!plan_rp[par])
                begin
                    plan_rp[par] = 1'b1;
                    plan_r[par]  = IDX_W'(order[k]);
                    placed       = 1'b1;
                end
            end
        end
        plan_n = n;
    endtask

    // children always point forward: shared subtrees, root 0
    task automatic plan_dag(int n);
        for (int i = 0; i < n; i++)
        begin
            plan_lp[i] = (i + 1 < n) && $urandom_range(0, 1);
            plan_l[i]  = IDX_W'(plan_lp[i] ? $urandom_range(i + 1, n - 1)
                                           : $urandom_range(0, 15));
            plan_rp[i] = (i + 1 < n) && $urandom_range(0, 1);
            plan_r[i]  = IDX_W'(plan_rp[i] ? $urandom_range(i + 1, n - 1)
                                           : $urandom_range(0, 15));
        end
        plan_n = n;
    endtask

    // root 0 never named, the rest may loop
    task automatic plan_tangled(int n);
        for (int i = 0; i < n; i++)
        begin
            plan_lp[i] = 1'($urandom_range(0, 1));
            plan_l[i]  = IDX_W'(plan_lp[i] ? $urandom_range(1, n - 1) : $urandom_range(0, 15));
            plan_rp[i] = 1'($urandom_range(0, 1));
            plan_r[i]  = IDX_W'(plan_rp[i] ? $urandom_range(1, n - 1) : $urandom_range(0, 15));
        end
        plan_n = n;
    endtask

    initial
    begin : stimulus
        int pick;
        int trees;
        int extra;
        rst_n         = 1'b0;
        in_valid      <= 1'b0;
        left_child    <= '0;
        left_present  <= 1'b0;
        right_child   <= '0;
        right_present <= 1'b0;
        last_node     <= 1'b0;
        nodes_sent    = 0;
        tx_eager      = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone leaf
        offer_node(4'd0, 1'b0, 4'd0, 1'b0, 1'b1);
        // root 0 with two leaves
        offer_node(4'd1, 1'b1, 4'd2, 1'b1, 1'b0);
        offer_node(4'd15, 1'b0, 4'd15, 1'b0, 1'b0);
        offer_node(4'd15, 1'b0, 4'd15, 1'b0, 1'b1);
        // root is node 1
        offer_node(4'd9, 1'b0, 4'd6, 1'b0, 1'b0);
        offer_node(4'd0, 1'b1, 4'd2, 1'b1, 1'b0);
        offer_node(4'd3, 1'b0, 4'd12, 1'b0, 1'b1);
        // child index far out of range
        offer_node(4'd0, 1'b0, 4'd15, 1'b1, 1'b1);
        // child index equal to node count
        offer_node(4'd2, 1'b1, 4'd0, 1'b0, 1'b0);
        offer_node(4'd0, 1'b0, 4'd0, 1'b0, 1'b1);
        // every node referenced
        offer_node(4'd1, 1'b1, 4'd0, 1'b0, 1'b0);
        offer_node(4'd0, 1'b0, 4'd0, 1'b1, 1'b1);
        // self loop, walk finds no leaf
        offer_node(4'd1, 1'b1, 4'd0, 1'b0, 1'b0);
        offer_node(4'd1, 1'b1, 4'd0, 1'b0, 1'b1);
        // shared child listed twice
        offer_node(4'd1, 1'b1, 4'd1, 1'b1, 1'b0);
        offer_node(4'd0, 1'b0, 4'd0, 1'b0, 1'b1);
        drain_leaves();

        trees = 0;
        while (nodes_sent < NODE_ITEMS)
        begin
            tx_eager = ($urandom_range(0, 3) == 0);
            pick     = $urandom_range(0, 99);
            if (pick < 58)
                plan_shaped($urandom_range(1, 16));
            else if (pick < 70)
                plan_dag($urandom_range(1, 16));
            else if (pick < 80)
                plan_tangled($urandom_range(2, 16));
            else if (pick < 90)
                plan_noise($urandom_range(1, 20));
            else
            begin
                plan_shaped(16);
                extra = $urandom_range(1, 4);
                for (int i = 16; i < 16 + extra; i++)
                begin
                    plan_l[i]  = IDX_W'($urandom_range(0, 15));
                    plan_lp[i] = 1'($urandom_range(0, 1));
                    plan_r[i]  = IDX_W'($urandom_range(0, 15));
                    plan_rp[i] = 1'($urandom_range(0, 1));
                end
                plan_n = 16 + extra;
            end
            offer_plan();
            trees++;
            if (trees % 10 == 0)
                drain_leaves();
        end

        drain_leaves();
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending_leaves == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
